// ===== rtl/nls_pkg.sv =====
// Shared types and constants for the nearest light selector.
// Holds the transaction payload structs, operation codes and the controller command bundle.
// No dependencies.
package nls_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int MAX_SELECT  = 8;

  localparam int SLOT_W  = $clog2(STORE_DEPTH);
  localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
  localparam int RANK_W  = 3;
  localparam int CFG_W   = 4;
  localparam int COORD_W = 16;
  localparam int DIST_W  = 34;
  localparam int KEY_W   = DIST_W + 1;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]                 func;
    logic                       light_kind;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
  } nls_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [RANK_W-1:0] rank;
    logic [DIST_W-1:0] distance_sq;
    logic              is_directional;
    logic              status;
    logic              last;
  } nls_out_t;

  typedef enum logic [1:0] {
    OSEL_APPEND,
    OSEL_FULL,
    OSEL_QUERY
  } nls_osel_t;

  typedef struct packed {
    logic              item_ld;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              sort_clr;
    logic              out_ld;
    nls_osel_t         out_sel;
    logic [SLOT_W-1:0] out_slot;
    logic [RANK_W-1:0] out_rank;
    logic              out_last;
  } nls_cmd_t;

endpackage

// ===== rtl/nls_ctrl.sv =====
// Controller for the nearest light selector: handshakes, light count, scan and emit sequencing.
// Depends on nls_pkg; drives the command bundle of nls_datapath.
module nls_ctrl
  import nls_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             pipe_busy,
  output nls_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CFG_W-1:0]  max_en_r, max_en_nxt;
  logic [CFG_W-1:0]  sel_n_r, sel_n_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              full_r, full_nxt;
  logic [SLOT_W-1:0] resp_slot_r, resp_slot_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              accept;
  logic              out_free;
  logic [CFG_W-1:0]  query_n;
  logic              emit_last;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign query_n   = (count_r < CNT_W'(max_en_r)) ? count_r[CFG_W-1:0] : max_en_r;
  assign emit_last = (({1'b0, rank_r} + CFG_W'(1)) == sel_n_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    max_en_nxt    = max_en_r;
    sel_n_nxt     = sel_n_r;
    idx_nxt       = idx_r;
    rank_nxt      = rank_r;
    full_nxt      = full_r;
    resp_slot_nxt = resp_slot_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.out_sel   = OSEL_APPEND;
    cmd.wr_addr   = count_r[SLOT_W-1:0];
    cmd.rd_addr   = idx_r;
    cmd.out_slot  = resp_slot_r;
    cmd.out_rank  = rank_r;

    if (cfg_we && (cfg_wdata <= CFG_W'(MAX_SELECT))) begin
      max_en_nxt = cfg_wdata;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.item_ld = 1'b1;
          case (in_func)
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            FUNC_APPEND: begin
              resp_slot_nxt = count_r[SLOT_W-1:0];
              if (count_r < CNT_W'(STORE_DEPTH)) begin
                cmd.wr_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                full_nxt  = 1'b0;
              end else begin
                full_nxt  = 1'b1;
              end
              state_nxt = S_RESP;
            end
            FUNC_QUERY: begin
              if (query_n != '0) begin
                cmd.sort_clr = 1'b1;
                sel_n_nxt    = query_n;
                idx_nxt      = '0;
                state_nxt    = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_sel   = full_r ? OSEL_FULL : OSEL_APPEND;
          cmd.out_last  = 1'b1;
          cmd.out_rank  = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        idx_nxt   = idx_r + SLOT_W'(1);
        if (({1'b0, idx_r} + CNT_W'(1)) == count_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait for the last read to clear the distance pipeline and sorter
        if (!pipe_busy) begin
          rank_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_sel   = OSEL_QUERY;
          cmd.out_last  = emit_last;
          out_valid_nxt = 1'b1;
          rank_nxt      = rank_r + RANK_W'(1);
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_en_r    <= CFG_W'(MAX_SELECT);
      sel_n_r     <= '0;
      idx_r       <= '0;
      rank_r      <= '0;
      full_r      <= 1'b0;
      resp_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_en_r    <= max_en_nxt;
      sel_n_r     <= sel_n_nxt;
      idx_r       <= idx_nxt;
      rank_r      <= rank_nxt;
      full_r      <= full_nxt;
      resp_slot_r <= resp_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/nls_datapath.sv =====
// Datapath for the nearest light selector: light store, distance pipeline,
// insertion sorter of the nearest lights, and the result register.
// Depends on nls_pkg; commanded by nls_ctrl.
module nls_datapath
  import nls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  nls_in_t  in_data,
  input  nls_cmd_t cmd,
  output logic     pipe_busy,
  output nls_out_t out_data
);

  localparam int ENTRY_W = 3 * COORD_W + 1;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;

  // store entry: {directional, x, y, z}
  logic [ENTRY_W-1:0] mem [STORE_DEPTH];

  nls_in_t item_r;

  // stage 0: store read
  logic [ENTRY_W-1:0] rd_data_r;
  logic               v0_r;
  logic [SLOT_W-1:0]  slot0_r;

  // stage 1: coordinate differences
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic                     v1_r, dir1_r;
  logic [SLOT_W-1:0]        slot1_r;

  // stage 2: squares
  logic [SQ_W-1:0]   sqx_r, sqy_r, sqz_r;
  logic              v2_r, dir2_r;
  logic [SLOT_W-1:0] slot2_r;

  // stage 3: sort key
  logic [KEY_W-1:0]  key3_r;
  logic              v3_r;
  logic [SLOT_W-1:0] slot3_r;

  // sorted list, nearest first
  logic [KEY_W-1:0]  skey_r  [MAX_SELECT];
  logic [SLOT_W-1:0] sslot_r [MAX_SELECT];
  logic [MAX_SELECT-1:0] svld_r;
  logic [MAX_SELECT-1:0] gt;

  nls_out_t out_r;

  logic signed [DIFF_W-1:0] rx, ry, rz, qx, qy, qz;
  logic signed [PROD_W-1:0] px, py, pz;
  logic [DIST_W-1:0]        dist_sum;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= {in_data.light_kind, in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  assign rx = {rd_data_r[3*COORD_W-1], rd_data_r[3*COORD_W-1:2*COORD_W]};
  assign ry = {rd_data_r[2*COORD_W-1], rd_data_r[2*COORD_W-1:COORD_W]};
  assign rz = {rd_data_r[COORD_W-1],   rd_data_r[COORD_W-1:0]};
  assign qx = {item_r.pos_x[COORD_W-1], item_r.pos_x};
  assign qy = {item_r.pos_y[COORD_W-1], item_r.pos_y};
  assign qz = {item_r.pos_z[COORD_W-1], item_r.pos_z};

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  assign dist_sum = DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      item_r <= in_data;
    end
    slot0_r <= cmd.rd_addr;
    dx_r    <= qx - rx;
    dy_r    <= qy - ry;
    dz_r    <= qz - rz;
    dir1_r  <= rd_data_r[ENTRY_W-1];
    slot1_r <= slot0_r;
    sqx_r   <= px[SQ_W-1:0];
    sqy_r   <= py[SQ_W-1:0];
    sqz_r   <= pz[SQ_W-1:0];
    dir2_r  <= dir1_r;
    slot2_r <= slot1_r;
    // directional lights key just above any reachable distance
    key3_r  <= dir2_r ? {1'b1, {DIST_W{1'b0}}} : {1'b0, dist_sum};
    slot3_r <= slot2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= cmd.rd_en;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign pipe_busy = v0_r | v1_r | v2_r | v3_r;

  // strict compare keeps earlier (lower) slots ahead on equal keys
  always_comb begin
    for (int j = 0; j < MAX_SELECT; j++) begin
      gt[j] = !svld_r[j] || (skey_r[j] > key3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.sort_clr) begin
      svld_r <= '0;
    end else if (v3_r) begin
      for (int j = 0; j < MAX_SELECT; j++) begin
        if (gt[j]) begin
          if (j == 0 || !gt[(j == 0) ? 0 : j - 1]) begin
            svld_r[j] <= 1'b1;
          end else begin
            svld_r[j] <= svld_r[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      for (int j = 0; j < MAX_SELECT; j++) begin
        if (gt[j]) begin
          if (j == 0 || !gt[(j == 0) ? 0 : j - 1]) begin
            skey_r[j]  <= key3_r;
            sslot_r[j] <= slot3_r;
          end else begin
            skey_r[j]  <= skey_r[(j == 0) ? 0 : j - 1];
            sslot_r[j] <= sslot_r[(j == 0) ? 0 : j - 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_r.rank   <= cmd.out_rank;
      out_r.last   <= cmd.out_last;
      case (cmd.out_sel)
        OSEL_APPEND: begin
          out_r.slot           <= cmd.out_slot;
          out_r.distance_sq    <= '0;
          out_r.is_directional <= item_r.light_kind;
          out_r.status         <= 1'b0;
        end
        OSEL_FULL: begin
          out_r.slot           <= '0;
          out_r.distance_sq    <= '0;
          out_r.is_directional <= 1'b0;
          out_r.status         <= 1'b1;
        end
        OSEL_QUERY: begin
          out_r.slot           <= sslot_r[cmd.out_rank];
          out_r.distance_sq    <= skey_r[cmd.out_rank][DIST_W-1:0];
          out_r.is_directional <= skey_r[cmd.out_rank][DIST_W];
          out_r.status         <= 1'b0;
        end
        default: begin
          out_r.slot           <= '0;
          out_r.distance_sq    <= '0;
          out_r.is_directional <= 1'b0;
          out_r.status         <= 1'b0;
        end
      endcase
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/nearest_light_selector_top.sv =====
// Nearest light selector: 64-entry light store with nearest-first query.
// Clear: no result. Append: one result via the response state; input stalls until it is loaded.
// Query: one store read per cycle over the stored lights, then a 5-stage distance and
// insertion-sort pipeline, then one result per cycle unless out_stall holds it, up to 8 (none
// for an empty store or max_enabled 0); input stays stalled until the last result is loaded.
// Synchronous active-low reset empties the store and sets max_enabled to 8.
// Depends on nls_pkg, nls_ctrl and nls_datapath.
module nearest_light_selector_top
  import nls_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  nls_in_t          in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output nls_out_t         out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  nls_cmd_t cmd;
  logic     pipe_busy;

  nls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pipe_busy (pipe_busy),
    .cmd       (cmd)
  );

  nls_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .pipe_busy (pipe_busy),
    .out_data  (out_data)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for nearest_light_selector_top: light store, append and
// nearest-first query, checked against an in-bench predictor of the selection.
// Depends on nls_pkg and the RTL under rtl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nls_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int IDLE_GUARD  = 100;      // longer than the longest query scan with no output
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_WAIT    = 11;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  nls_in_t          in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  nls_out_t         out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  nearest_light_selector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  logic signed [COORD_W-1:0] light_x [STORE_DEPTH];
  logic signed [COORD_W-1:0] light_y [STORE_DEPTH];
  logic signed [COORD_W-1:0] light_z [STORE_DEPTH];
  logic                      light_dir [STORE_DEPTH];
  int unsigned               light_total = 0;
  int unsigned               select_limit = MAX_SELECT;

  nls_out_t awaited_results [$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       calm_left [2] = '{0, 0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Per-transaction wait, with occasional stretches of back-to-back traffic.
  function automatic int draw_wait(input int side);
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [DIST_W-1:0] axis_sq(logic signed [COORD_W-1:0] a,
                                                logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? -d : d;
    return DIST_W'(m) * DIST_W'(m);
  endfunction

  function automatic void predict_selection(nls_in_t it);
    logic [KEY_W-1:0] key [STORE_DEPTH];
    bit               taken [STORE_DEPTH];
    int               n;
    int               best;
    nls_out_t         r;
    r = '0;
    case (it.func)
      FUNC_CLEAR: light_total = 0;
      FUNC_APPEND: begin
        r.last = 1'b1;
        if (light_total >= STORE_DEPTH) begin
          r.status = 1'b1;
        end else begin
          light_x[light_total]   = it.pos_x;
          light_y[light_total]   = it.pos_y;
          light_z[light_total]   = it.pos_z;
          light_dir[light_total] = it.light_kind;
          r.slot           = SLOT_W'(light_total);
          r.is_directional = it.light_kind;
          light_total++;
        end
        awaited_results.push_back(r);
      end
      FUNC_QUERY: begin
        n = select_limit;
        if (n > light_total) n = light_total;
        if (n > MAX_SELECT) n = MAX_SELECT;
        for (int i = 0; i < light_total; i++) begin
          taken[i] = 1'b0;
          // directional lights sort after every positioned light
          if (light_dir[i]) key[i] = {1'b1, {DIST_W{1'b0}}};
          else key[i] = KEY_W'(axis_sq(it.pos_x, light_x[i])) +
                        KEY_W'(axis_sq(it.pos_y, light_y[i])) +
                        KEY_W'(axis_sq(it.pos_z, light_z[i]));
        end
        for (int rk = 0; rk < n; rk++) begin
          best = -1;
          for (int i = 0; i < light_total; i++)
            if (!taken[i] && (best < 0 || key[i] < key[best])) best = i;
          taken[best] = 1'b1;
          r = '0;
          r.slot           = SLOT_W'(best);
          r.rank           = RANK_W'(rk);
          r.is_directional = light_dir[best];
          r.distance_sq    = light_dir[best] ? '0 : key[best][DIST_W-1:0];
          r.last           = (rk == n - 1);
          awaited_results.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    nls_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, got slot=%0d rank=%0d dist=%0d %s",
                 $time, out_data.slot, out_data.rank, out_data.distance_sq,
                 $sformatf("dir=%0b status=%0b last=%0b", out_data.is_directional,
                           out_data.status, out_data.last));
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_data.slot !== exp_r.slot || out_data.rank !== exp_r.rank ||
            out_data.distance_sq !== exp_r.distance_sq ||
            out_data.is_directional !== exp_r.is_directional ||
            out_data.status !== exp_r.status || out_data.last !== exp_r.last) begin
          error_count++;
          $display("%0t: mismatch: expected slot=%0d rank=%0d dist=%0d %s",
                   $time, exp_r.slot, exp_r.rank, exp_r.distance_sq,
                   $sformatf("dir=%0b status=%0b last=%0b", exp_r.is_directional,
                             exp_r.status, exp_r.last));
          $display("%0t:           actual slot=%0d rank=%0d dist=%0d %s",
                   $time, out_data.slot, out_data.rank, out_data.distance_sq,
                   $sformatf("dir=%0b status=%0b last=%0b", out_data.is_directional,
                             out_data.status, out_data.last));
        end
      end
    end
  end

  // Result-side backpressure
  initial begin
    int k;
    forever begin
      k = draw_wait(1);
      if (k > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (k - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_transaction(nls_in_t it);
    int k;
    k = draw_wait(0);
    @(negedge clk);
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_selection(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic write_select_limit(logic [CFG_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (v <= MAX_SELECT) select_limit = v;   // larger values are dropped
  endtask

  function automatic nls_in_t make_item(logic [1:0] f, logic kind, int x, int y, int z);
    nls_in_t it;
    it.func       = f;
    it.light_kind = kind;
    it.pos_x      = COORD_W'(x);
    it.pos_y      = COORD_W'(y);
    it.pos_z      = COORD_W'(z);
    return it;
  endfunction

  // Full range, extremes, or a coarse grid that produces distance ties.
  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return ($urandom_range(0, 7) * 256) - 1024;
    endcase
  endfunction

  function automatic nls_in_t rand_item(logic [1:0] f);
    return make_item(f, ($urandom_range(0, 4) == 0), rand_coord(), rand_coord(),
                     rand_coord());
  endfunction

  task automatic test_directed();
    send_transaction(make_item(FUNC_QUERY, 1'b0, 0, 0, 0));          // empty store
    send_transaction(make_item(FUNC_APPEND, 1'b0, -32768, -32768, -32768));
    send_transaction(make_item(FUNC_APPEND, 1'b0, 32767, 32767, 32767));
    send_transaction(make_item(FUNC_APPEND, 1'b1, 0, 0, 0));
    send_transaction(make_item(FUNC_APPEND, 1'b0, 0, 0, 0));
    send_transaction(make_item(FUNC_APPEND, 1'b0, 0, 0, 0));          // tie with slot 3
    send_transaction(make_item(FUNC_UNUSED, 1'b1, -1, -1, -1));       // ignored
    send_transaction(make_item(FUNC_QUERY, 1'b0, 32767, 32767, 32767)); // largest distance
    send_transaction(make_item(FUNC_QUERY, 1'b0, 0, 0, 0));
    send_transaction(make_item(FUNC_QUERY, 1'b1, -32768, 32767, 0));
    send_transaction(make_item(FUNC_CLEAR, 1'b0, 0, 0, 0));
    send_transaction(make_item(FUNC_QUERY, 1'b0, 100, -100, 5));
    send_transaction(make_item(FUNC_APPEND, 1'b1, -1, -1, -1));
    send_transaction(make_item(FUNC_QUERY, 1'b0, 1, 1, 1));           // directional only
    send_transaction(make_item(FUNC_APPEND, 1'b0, 256, -256, 128));
    send_transaction(make_item(FUNC_QUERY, 1'b0, -32768, -32768, -32768));
    send_transaction(make_item(FUNC_QUERY, 1'b1, 256, -256, 128));    // zero distance
  endtask

  task automatic test_store_full();
    send_transaction(make_item(FUNC_CLEAR, 1'b0, 0, 0, 0));
    repeat (STORE_DEPTH) send_transaction(rand_item(FUNC_APPEND));
    repeat (3) send_transaction(rand_item(FUNC_APPEND));             // store full
    repeat (4) send_transaction(rand_item(FUNC_QUERY));
  endtask

  task automatic test_select_limit_sweep();
    logic [CFG_W-1:0] limits [7] = '{4'd0, 4'd1, 4'd15, 4'd8, 4'd9, 4'd3, 4'd8};
    foreach (limits[i]) begin
      write_select_limit(limits[i]);
      repeat (3) send_transaction(rand_item(FUNC_QUERY));
    end
  endtask

  task automatic test_random_traffic();
    int op;
    for (int phase = 0; phase < 5; phase++) begin
      write_select_limit(CFG_W'($urandom_range(0, 15)));
      repeat (65) begin
        op = $urandom_range(0, 99);
        if (op < 3) send_transaction(rand_item(FUNC_CLEAR));
        else if (op < 5) send_transaction(rand_item(FUNC_UNUSED));
        else if (op < 55) send_transaction(rand_item(FUNC_APPEND));
        else send_transaction(rand_item(FUNC_QUERY));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_store_full();
    test_select_limit_sweep();
    test_random_traffic();
    write_select_limit(4'd8);
    test_store_full();
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/nls_pkg.sv
rtl/nls_ctrl.sv
rtl/nls_datapath.sv
rtl/nearest_light_selector_top.sv
dv/testbench.sv
